// ----- hw/rtl/asfc_pkg.sv -----
// Shared types and constants of the audio sample format converter.
`default_nettype none

package asfc_pkg;

  // Sample type codes, as written to the in_format and out_format registers.
  typedef enum logic [2:0] {
    FMT_FLOAT = 3'd0,
    FMT_INT32 = 3'd1,
    FMT_INT16 = 3'd2,
    FMT_UINT8 = 3'd3,
    FMT_INT8  = 3'd4
  } fmt_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IN_FORMAT  = 2'd0,
    CFG_OUT_FORMAT = 2'd1,
    CFG_OUT_SWAP   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 3;
  localparam int unsigned SampleW  = 32;

  // Full scale of the signed 32-bit intermediate.
  localparam logic [30:0] FullScale = 31'h7fff_ffff;

  typedef struct packed {
    logic [2:0] in_format;
    logic [2:0] out_format;
    logic       out_swap;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/asfc_to_common.sv -----
// Source sample to signed 32-bit intermediate.
`default_nettype none

module asfc_to_common (
  input  logic [2:0]         in_format_i,
  input  logic [31:0]        raw_i,
  output logic signed [31:0] common_o
);

  // floor(7 * a / 127) for a in 0..127: the fraction of 0x7fffffff / 127.
  function automatic logic [2:0] frac7(input logic [6:0] a);
    logic [9:0] t;
    logic [2:0] n;
    t = 10'(a) * 10'd7;
    n = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      if (t >= 10'(127 * k)) n = 3'(k);
    end
    return n;
  endfunction

  // Float path
  logic        f_sign;
  logic [7:0]  f_exp;
  logic [22:0] f_frac;
  logic [23:0] f_mant;
  logic [7:0]  f_shamt;
  logic [54:0] f_prod;
  logic [55:0] f_rnd;
  logic [55:0] f_shift;
  logic [30:0] f_mag;

  // Integer paths
  logic signed [15:0] i16_v;
  logic [14:0]        i16_a;
  logic [30:0]        i16_mag;
  logic [8:0]         u8_d;
  logic [6:0]         u8_a;
  logic signed [7:0]  i8_v;
  logic [6:0]         i8_a;
  logic [6:0]         b8_a;
  logic [30:0]        b8_mag;
  logic               neg;
  logic [30:0]        mag;

  always_comb begin
    f_sign  = raw_i[31];
    f_exp   = raw_i[30:23];
    f_frac  = raw_i[22:0];
    f_mant  = (f_exp == 8'd0) ? {1'b0, f_frac} : {1'b1, f_frac};
    f_shamt = (f_exp == 8'd0) ? 8'd149 : 8'd150 - f_exp;
    // exact m * 0x7fffffff, then round to 53 bits as double math does
    f_prod  = ({31'd0, f_mant} << 31) - {31'd0, f_mant};
    if (f_prod[54]) begin
      f_rnd = 56'({1'b0, f_prod[54:2]} + 54'(f_prod[1] & (f_prod[0] | f_prod[2]))) << 2;
    end else if (f_prod[53]) begin
      f_rnd = 56'({1'b0, f_prod[53:1]} + 54'(f_prod[0] & f_prod[1])) << 1;
    end else begin
      f_rnd = {1'b0, f_prod};
    end
    f_shift = f_rnd >> f_shamt;
    if (f_exp == 8'hff && f_frac != 23'd0) begin
      f_mag = 31'd0;                      // NaN reads as zero
    end else if (f_exp >= 8'd127) begin
      f_mag = asfc_pkg::FullScale;        // clamp to +/-1.0
    end else begin
      f_mag = f_shift[30:0];
    end

    i16_v   = (raw_i[15:0] == 16'h8000) ? 16'sh8001 : $signed(raw_i[15:0]);
    i16_a   = i16_v[15] ? 15'(-i16_v) : i16_v[14:0];
    // 0x7fffffff / 32767 = 65538 + 1/32767
    i16_mag = 31'(31'(i16_a) * 31'd65538) + 31'(i16_a == 15'h7fff);

    u8_d = (raw_i[7:0] == 8'd0) ? 9'h181 : {1'b0, raw_i[7:0]} - 9'd128;
    u8_a = u8_d[8] ? 7'(-u8_d) : u8_d[6:0];
    i8_v = (raw_i[7:0] == 8'h80) ? 8'sh81 : $signed(raw_i[7:0]);
    i8_a = i8_v[7] ? 7'(-i8_v) : i8_v[6:0];
    b8_a = (in_format_i == asfc_pkg::FMT_UINT8) ? u8_a : i8_a;
    // 0x7fffffff / 127 = 16909320 + 7/127
    b8_mag = 31'(31'(b8_a) * 31'd16909320) + 31'(frac7(b8_a));

    neg = 1'b0;
    mag = 31'd0;
    common_o = 32'sd0;
    case (in_format_i)
      asfc_pkg::FMT_FLOAT: begin
        neg = f_sign;
        mag = f_mag;
      end
      asfc_pkg::FMT_INT16: begin
        neg = i16_v[15];
        mag = i16_mag;
      end
      asfc_pkg::FMT_UINT8: begin
        neg = u8_d[8];
        mag = b8_mag;
      end
      asfc_pkg::FMT_INT8: begin
        neg = i8_v[7];
        mag = b8_mag;
      end
      default: begin
        neg = 1'b0;
        mag = 31'd0;
      end
    endcase
    if (in_format_i == asfc_pkg::FMT_INT32) begin
      common_o = (raw_i == 32'h8000_0000) ? 32'sh8000_0001 : $signed(raw_i);
    end else begin
      common_o = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/asfc_from_common.sv -----
// Intermediate to target sample, with pass-through and byte swap.
`default_nettype none

module asfc_from_common (
  input  asfc_pkg::cfg_t     cfg_i,
  input  logic [31:0]        raw_i,
  input  logic signed [31:0] common_i,
  output logic [31:0]        sample_o
);

  function automatic logic [30:0] msb_zeros(input logic [30:0] a);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (a[i]) n = 5'(30 - i);
    end
    return {26'd0, n};
  endfunction

  logic        neg;
  logic [30:0] a;
  logic [4:0]  lz;
  logic [92:0] rep;
  logic [53:0] dmant;
  logic [24:0] fm;
  logic        fup;
  logic [7:0]  fexp;
  logic [22:0] ffrac;
  logic [31:0] fbits;
  logic signed [31:0] b16;
  logic signed [31:0] b8;
  logic signed [31:0] q16;
  logic signed [31:0] q8;
  logic [31:0] mask;
  logic [31:0] conv;
  logic [31:0] res;

  always_comb begin
    // Float: a / 0x7fffffff is the 31-bit block of a repeated without end
    neg   = common_i[31];
    a     = neg ? 31'(-common_i) : common_i[30:0];
    lz    = 5'(msb_zeros(a));
    rep   = {a, a, a} << lz;
    dmant = {1'b0, rep[92:40]} + 54'(rep[39]);   // double rounding, sticky always set
    fm    = {1'b0, dmant[52:29]};
    fup   = dmant[28] & ((|dmant[27:0]) | dmant[29]);
    fm    = fm + 25'(fup);
    fexp  = 8'd126 - 8'(lz);
    ffrac = fm[22:0];
    if (dmant[53] || fm[24]) begin
      fexp  = fexp + 8'd1;
      ffrac = 23'd0;
    end
    if (a == 31'd0) begin
      fbits = 32'd0;
    end else if (a == asfc_pkg::FullScale) begin
      fbits = {neg, 8'd127, 23'd0};
    end else begin
      fbits = {neg, fexp, ffrac};
    end

    // Truncating division by powers of two
    b16 = common_i + (neg ? 32'sd65535 : 32'sd0);
    b8  = common_i + (neg ? 32'sh00ff_ffff : 32'sd0);
    q16 = b16 >>> 16;
    q8  = b8 >>> 24;

    mask = 32'hffff_ffff;
    conv = 32'd0;
    case (cfg_i.out_format)
      asfc_pkg::FMT_FLOAT: conv = fbits;
      asfc_pkg::FMT_INT32: conv = common_i;
      asfc_pkg::FMT_INT16: begin
        conv = {16'd0, q16[15:0]};
        mask = 32'h0000_ffff;
      end
      asfc_pkg::FMT_UINT8: begin
        conv = {24'd0, q8[7:0] ^ 8'h80};
        mask = 32'h0000_00ff;
      end
      asfc_pkg::FMT_INT8: begin
        conv = {24'd0, q8[7:0]};
        mask = 32'h0000_00ff;
      end
      default: begin
        conv = 32'd0;
        mask = 32'd0;
      end
    endcase

    res = (cfg_i.in_format == cfg_i.out_format) ? (raw_i & mask) : conv;
    if (cfg_i.out_swap) begin
      if (mask == 32'hffff_ffff) begin
        res = {res[7:0], res[15:8], res[23:16], res[31:24]};
      end else if (mask == 32'h0000_ffff) begin
        res = {16'd0, res[7:0], res[15:8]};
      end
    end
    sample_o = res & mask;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/audio_sample_format_converter_unit.sv -----
// Top level of the audio sample format converter.
//
//  channel   direction  signals                                   handshake
//  --------  ---------  ----------------------------------------  ---------------------
//  request   in         start_i, sample_in_i, last_sample_i       start_i & !busy_o
//  result    out        done_o, sample_out_o, last_out_o          done_o, one cycle
//  config    in         cfg_we_i, cfg_idx_i, cfg_data_i           cfg_we_i
//
// A request is taken every cycle; busy_o stays low. After acceptance the result
// passes the input register, the intermediate register (after the int32
// normalization) and the result register (after target formatting and swap).
// Reset clears the stage valid bits and sets in_format=int32, out_format=int32,
// out_swap=0. The receiver cannot stall, so nothing holds the pipeline.
`default_nettype none

module audio_sample_format_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] sample_in_i,
  input  logic        last_sample_i,
  output logic        done_o,
  output logic [31:0] sample_out_o,
  output logic        last_out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [asfc_pkg::CfgDataW-1:0] cfg_data_i
);

  asfc_pkg::cfg_t cfg_q;

  logic               acc;
  logic               s0_vld_q;
  logic [31:0]        s0_raw_q;
  logic               s0_last_q;
  logic signed [31:0] common_d;
  logic               s1_vld_q;
  logic [31:0]        s1_raw_q;
  logic               s1_last_q;
  logic signed [31:0] s1_common_q;
  logic [31:0]        sample_d;
  logic               out_vld_q;
  logic [31:0]        out_sample_q;
  logic               out_last_q;

  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  // Configuration writes; writes to an unused index drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_format  <= asfc_pkg::FMT_INT32;
      cfg_q.out_format <= asfc_pkg::FMT_INT32;
      cfg_q.out_swap   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asfc_pkg::CFG_IN_FORMAT:  cfg_q.in_format  <= cfg_data_i[2:0];
        asfc_pkg::CFG_OUT_FORMAT: cfg_q.out_format <= cfg_data_i[2:0];
        asfc_pkg::CFG_OUT_SWAP:   cfg_q.out_swap   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Valid bits advance every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s0_vld_q  <= acc;
      s1_vld_q  <= s0_vld_q;
      out_vld_q <= s1_vld_q;
    end
  end

  // Payload registers; hold when no request is in the stage.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_raw_q  <= sample_in_i;
      s0_last_q <= last_sample_i;
    end
    if (s0_vld_q) begin
      s1_raw_q    <= s0_raw_q;
      s1_last_q   <= s0_last_q;
      s1_common_q <= common_d;
    end
    if (s1_vld_q) begin
      out_sample_q <= sample_d;
      out_last_q   <= s1_last_q;
    end
  end

  // Normalize the source sample to the signed int32 intermediate.
  asfc_to_common u_to_common (
    .in_format_i (cfg_q.in_format),
    .raw_i       (s0_raw_q),
    .common_o    (common_d)
  );

  // Write the target type, or pass the raw bits when the types match.
  asfc_from_common u_from_common (
    .cfg_i    (cfg_q),
    .raw_i    (s1_raw_q),
    .common_i (s1_common_q),
    .sample_o (sample_d)
  );

  assign done_o       = out_vld_q;
  assign sample_out_o = out_sample_q;
  assign last_out_o   = out_last_q;

  // Every accepted request yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |-> ##3 done_o)
    else $error("accepted request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(acc, 3))
    else $error("result without a request");

  // An unknown target type always gives zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cfg_q.out_format > asfc_pkg::FMT_INT8) |-> sample_out_o == 32'd0)
    else $error("unknown target type produced nonzero sample");

  // 8-bit targets carry nothing above bit 7.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cfg_q.out_format == asfc_pkg::FMT_UINT8 ||
                cfg_q.out_format == asfc_pkg::FMT_INT8)) |-> sample_out_o[31:8] == 24'd0)
    else $error("8-bit result has upper bits set");

endmodule

`default_nettype wire

// ----- tb/sv/tb_audio_sample_format_converter_unit.sv -----
// Self-checking testbench for the audio sample format converter unit.
`timescale 1ns / 100ps

module tb_audio_sample_format_converter_unit;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] sample_in_i = '0;
  logic        last_sample_i = 1'b0;
  logic        done_o;
  logic [31:0] sample_out_o;
  logic        last_out_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [asfc_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // Shadow copy of the configuration registers, changed only while idle.
  logic [2:0] src_fmt = asfc_pkg::FMT_INT32;
  logic [2:0] dst_fmt = asfc_pkg::FMT_INT32;
  logic       swap_en = 1'b0;

  sample_t sample_requests[$];   // requests not yet driven
  sample_t expected_samples[$];  // predicted results in order
  bit      failed = 1'b0;
  bit      no_idle = 1'b0;
  int      idle_cnt = 0;
  int      stall_cycles = 0;

  audio_sample_format_converter_unit dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Float to int32 intermediate: NaN to zero, clamp to [-1,1], truncate.
  function automatic int float_to_common(logic [31:0] r);
    logic [7:0] e;
    real        x;
    e = r[30:23];
    if (e == 8'hff) begin
      if (r[22:0] != 0) return 0;
      x = r[31] ? -1.0 : 1.0;
    end else if (e == 8'h00) begin
      // Denormals are far below one step of full scale.
      x = 0.0;
    end else begin
      x = $bitstoreal({r[31], {3'b000, e} + 11'd896, r[22:0], 29'b0});
      if (x < -1.0) x = -1.0;
      else if (x > 1.0) x = 1.0;
    end
    return $rtoi(x * 2147483647.0);
  endfunction

  // int32 intermediate to float: double division, round to nearest even.
  function automatic logic [31:0] common_to_float(int v);
    real         d;
    logic [63:0] b;
    logic [33:0] kept;
    logic [28:0] rem;
    logic [10:0] e11;
    if (v == 0) return '0;
    d = real'(v) / 2147483647.0;
    b = $realtobits(d);
    kept = {b[62:52], b[51:29]};
    rem = b[28:0];
    if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && kept[0])) kept = kept + 1;
    e11 = kept[33:23] - 11'd896;
    return {b[63], e11[7:0], kept[22:0]};
  endfunction

  function automatic int to_common(logic [2:0] fmt, logic [31:0] r);
    longint v;
    case (fmt)
      asfc_pkg::FMT_FLOAT: return float_to_common(r);
      asfc_pkg::FMT_INT32: begin
        if (r == 32'h8000_0000) return -32'sd2147483647;
        return int'(r);
      end
      asfc_pkg::FMT_INT16: begin
        v = longint'($signed(r[15:0]));
        if (v == -32768) v++;
        return int'(v * 2147483647 / 32767);
      end
      asfc_pkg::FMT_UINT8: begin
        v = longint'(r[7:0]);
        if (v == 0) v++;
        return int'((v - 128) * 2147483647 / 127);
      end
      asfc_pkg::FMT_INT8: begin
        v = longint'($signed(r[7:0]));
        if (v == -128) v++;
        return int'(v * 2147483647 / 127);
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] from_common(logic [2:0] fmt, int v);
    int q;
    case (fmt)
      asfc_pkg::FMT_FLOAT: return common_to_float(v);
      asfc_pkg::FMT_INT32: return v;
      asfc_pkg::FMT_INT16: begin
        q = v / 65536;
        return {16'h0, q[15:0]};
      end
      asfc_pkg::FMT_UINT8: begin
        q = v / 16777216 + 128;
        return {24'h0, q[7:0]};
      end
      asfc_pkg::FMT_INT8: begin
        q = v / 16777216;
        return {24'h0, q[7:0]};
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] width_mask(logic [2:0] fmt);
    case (fmt)
      asfc_pkg::FMT_INT16:                     return 32'h0000_ffff;
      asfc_pkg::FMT_UINT8, asfc_pkg::FMT_INT8: return 32'h0000_00ff;
      default:                                 return 32'hffff_ffff;
    endcase
  endfunction

  function automatic sample_t convert_sample(sample_t req);
    sample_t     res;
    logic [31:0] s;
    res.last = req.last;
    if (dst_fmt > asfc_pkg::FMT_INT8) begin
      s = '0;
    end else begin
      if (src_fmt == dst_fmt) s = req.sample & width_mask(dst_fmt);
      else s = from_common(dst_fmt, to_common(src_fmt, req.sample));
      if (swap_en) begin
        if (dst_fmt == asfc_pkg::FMT_FLOAT || dst_fmt == asfc_pkg::FMT_INT32)
          s = {s[7:0], s[15:8], s[23:16], s[31:24]};
        else if (dst_fmt == asfc_pkg::FMT_INT16) s = {16'h0, s[7:0], s[15:8]};
      end
      s &= width_mask(dst_fmt);
    end
    res.sample = s;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: take requests from the queue, idle in random bursts
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      // Predict the request accepted at this edge.
      if (start_i && !busy_o)
        expected_samples.push_back(convert_sample('{sample_in_i, last_sample_i}));
      if (!start_i || !busy_o) begin
        if (idle_cnt > 0) begin
          idle_cnt <= idle_cnt - 1;
          start_i  <= 1'b0;
        end else if (sample_requests.size() > 0) begin
          sample_t nxt;
          nxt = sample_requests.pop_front();
          sample_in_i   <= nxt.sample;
          last_sample_i <= nxt.last;
          start_i       <= 1'b1;
          // Open an idle burst after this request now and then.
          if (!no_idle && $urandom_range(0, 7) == 0) idle_cnt <= $urandom_range(1, 18);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result with the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result sample_out=%h last_out=%b", sample_out_o, last_out_o);
        failed = 1'b1;
      end else begin
        sample_t want;
        want = expected_samples.pop_front();
        if (sample_out_o !== want.sample) begin
          $error("sample_out: expected %h actual %h", want.sample, sample_out_o);
          failed = 1'b1;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %b actual %b", want.last, last_out_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 2000) begin
        $display("tb_audio_sample_format_converter_unit: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Hold until every request is accepted and every result is back.
  task automatic drain();
    do @(negedge clk_i);
    while (sample_requests.size() != 0 || start_i || expected_samples.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(asfc_pkg::cfg_idx_e idx, logic [2:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      asfc_pkg::CFG_IN_FORMAT:  src_fmt = data;
      asfc_pkg::CFG_OUT_FORMAT: dst_fmt = data;
      default:                  swap_en = data[0];
    endcase
  endtask

  task automatic set_cfg(logic [2:0] src, logic [2:0] dst, logic [2:0] swp);
    write_cfg(asfc_pkg::CFG_IN_FORMAT, src);
    write_cfg(asfc_pkg::CFG_OUT_FORMAT, dst);
    write_cfg(asfc_pkg::CFG_OUT_SWAP, swp);
  endtask

  task automatic push_req(logic [31:0] s);
    sample_requests.push_back('{s, 1'($urandom_range(0, 1))});
  endtask

  // Random sample shaped for the source type.
  function automatic logic [31:0] rand_sample(logic [2:0] fmt);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      1: begin
        if (fmt == asfc_pkg::FMT_FLOAT) begin
          // Near full scale, with NaN, infinity and denormals mixed in.
          case ($urandom_range(0, 5))
            0:       r[30:23] = 8'hff;
            1:       r[30:23] = 8'h00;
            default: r[30:23] = 8'($urandom_range(100, 130));
          endcase
        end
        return r;
      end
      2: begin
        // Extreme codes of every width.
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return {r[31:16], 16'h8000};
          3: return {r[31:8], 8'h00};
          4: return {r[31:8], 8'h80};
          default: return {r[31:8], 8'hff};
        endcase
      end
      default: return {24'h0, r[7:0]} ^ {r[15], 31'h0};
    endcase
  endfunction

  initial begin
    logic [2:0] sf, df;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: float special cases into int32.
    set_cfg(asfc_pkg::FMT_FLOAT, asfc_pkg::FMT_INT32, 3'd0);
    push_req(32'h7fc0_0000);  // NaN
    push_req(32'h7f80_0000);  // +inf
    push_req(32'hc000_0000);  // -2.0
    push_req(32'h3f80_0000);  // 1.0
    push_req(32'hbf80_0000);  // -1.0
    push_req(32'h3f00_0000);  // 0.5
    push_req(32'h0000_0001);  // denormal
    drain();
    set_cfg(asfc_pkg::FMT_INT32, asfc_pkg::FMT_INT16, 3'd1);
    push_req(32'h8000_0000);
    push_req(32'h7fff_ffff);
    push_req(32'h0000_0000);
    drain();
    set_cfg(asfc_pkg::FMT_INT16, asfc_pkg::FMT_FLOAT, 3'd1);
    push_req(32'hffff_8000);
    push_req(32'h0000_7fff);
    push_req(32'h0000_0001);
    drain();
    set_cfg(asfc_pkg::FMT_UINT8, asfc_pkg::FMT_INT8, 3'd0);
    push_req(32'h0000_0000);
    push_req(32'h0000_00ff);
    drain();
    set_cfg(asfc_pkg::FMT_INT8, asfc_pkg::FMT_UINT8, 3'd1);
    push_req(32'h0000_0080);
    push_req(32'hffff_ff7f);
    drain();
    // Unknown source, unknown target, identical types with swap.
    set_cfg(3'd7, asfc_pkg::FMT_INT32, 3'd0);
    push_req(32'h1234_5678);
    drain();
    set_cfg(asfc_pkg::FMT_INT32, 3'd5, 3'd1);
    push_req(32'hdead_beef);
    drain();
    set_cfg(asfc_pkg::FMT_FLOAT, asfc_pkg::FMT_FLOAT, 3'd7);
    push_req(32'hff80_0001);
    push_req(32'h4080_0000);
    drain();

    // Random phases: mostly valid formats, sometimes unknown codes.
    for (int ph = 0; ph < 40; ph++) begin
      sf = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      df = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (ph >= 34) no_idle = 1'b1;
      set_cfg(sf, df, 3'($urandom));
      for (int i = 0; i < 35; i++) push_req(rand_sample(sf));
      drain();
    end

    if (!failed) begin
      $display("tb_audio_sample_format_converter_unit: PASS");
    end else begin
      $display("tb_audio_sample_format_converter_unit: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/asfc_pkg.sv
hw/rtl/asfc_to_common.sv
hw/rtl/asfc_from_common.sv
hw/rtl/audio_sample_format_converter_unit.sv
tb/sv/tb_audio_sample_format_converter_unit.sv
